// ----- rtl/core/rcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types, widths and the quadrature transition table of the rotary
// channel selector.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int ThrW      = 4;
  localparam int ChanW     = 4;
  localparam int CountW    = 5;
  localparam int LinesW    = 2;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 4;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 8;

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] REG_STEP_THRESHOLD = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_CHANNEL_MAX    = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_WRAP_ENABLE    = 2'd2;

  // reset values of the registers
  localparam logic [ThrW-1:0]  STEP_THRESHOLD_RST = 4'd6;
  localparam logic [ChanW-1:0] CHANNEL_MAX_RST    = 4'd3;
  localparam logic             WRAP_ENABLE_RST    = 1'b1;

  // count delta, indexed by {previous a, previous b, a, b}
  localparam logic signed [1:0] DELTA_TABLE [16] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [ThrW-1:0]  step_threshold;
    logic [ChanW-1:0] channel_max;
    logic             wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic [LinesW-1:0]        previous_lines;
    logic signed [CountW-1:0] detent_count;
    logic [ChanW-1:0]         current_channel;
  } state_t;

endpackage

// ----- rtl/core/rotary_channel_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_channel_selector
// Quadrature encoder decoder that steps a selected channel up or down.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample of encoder lines A and B per transfer. m_* returns
//   one result per sample: the selected channel and a changed flag.
//   cfg_we/cfg_index/cfg_wdata write step_threshold (0), channel_max (1) and
//   wrap_enable (2); write them only while no sample is in flight.
// Pipeline and throughput:
//   a sample enters an input register, the step logic runs between that
//   register and the output register, and m_tvalid comes from the output
//   register. One sample is taken every cycle while m_tready is high; the
//   decoder state (previous lines, detent count, channel) updates as the
//   sample moves into the output register, so back-to-back samples see
//   each other's effect.
// Reset:
//   rst clears the valid flags of both pipeline registers and the decoder
//   state, and loads the register defaults (threshold 6, max channel 3, wrap on).
// Stall:
//   with m_tready low the result holds; one more sample waits in the input
//   register, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module rotary_channel_selector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rcs_pkg::InDataW-1:0]       s_tdata,   // line_a, line_b
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rcs_pkg::OutDataW-1:0]      m_tdata,   // selected_channel[3:0], channel_changed
  input  logic                              cfg_we,
  input  logic [rcs_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [rcs_pkg::CfgDataW-1:0]      cfg_wdata
);

  rcs_pkg::cfg_t                cfg;
  rcs_pkg::state_t              state;
  rcs_pkg::state_t              state_next;
  logic                         in_valid;
  logic [1:0]                   in_lines;
  logic                         out_valid;
  logic [rcs_pkg::ChanW-1:0]    out_channel;
  logic                         out_changed;
  logic [rcs_pkg::ChanW-1:0]    step_channel;
  logic                         step_changed;
  logic                         advance;
  logic                         in_xfer;

  rcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcs_step u_step (
    .cfg              (cfg),
    .state            (state),
    .line_a           (in_lines[1]),
    .line_b           (in_lines[0]),
    .state_next       (state_next),
    .selected_channel (step_channel),
    .channel_changed  (step_changed)
  );

  // pipeline flow control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_lines <= {s_tdata[0], s_tdata[1]};
    end
  end

  // decoder state, updated as a sample leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel <= step_channel;
      out_changed <= step_changed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_changed, out_channel};

endmodule

// ----- rtl/core/rcs_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module rcs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rcs_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [rcs_pkg::CfgDataW-1:0]      cfg_wdata,
  output rcs_pkg::cfg_t                     cfg
);

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_threshold <= rcs_pkg::STEP_THRESHOLD_RST;
      cfg.channel_max    <= rcs_pkg::CHANNEL_MAX_RST;
      cfg.wrap_enable    <= rcs_pkg::WRAP_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcs_pkg::REG_STEP_THRESHOLD: cfg.step_threshold <= cfg_wdata[rcs_pkg::ThrW-1:0];
        rcs_pkg::REG_CHANNEL_MAX:    cfg.channel_max    <= cfg_wdata[rcs_pkg::ChanW-1:0];
        rcs_pkg::REG_WRAP_ENABLE:    cfg.wrap_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/rcs_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_step
// Per-sample update: transition lookup, detent count, channel step with
// wrap or clamp.
// ----------------------------------------------------------------------------
module rcs_step (
  input  rcs_pkg::cfg_t                 cfg,
  input  rcs_pkg::state_t               state,
  input  logic                          line_a,
  input  logic                          line_b,
  output rcs_pkg::state_t               state_next,
  output logic [rcs_pkg::ChanW-1:0]     selected_channel,
  output logic                          channel_changed
);

  logic signed [1:0]              delta;
  logic signed [rcs_pkg::CountW:0] sum;
  logic [rcs_pkg::ThrW-1:0]        thr;
  logic signed [rcs_pkg::CountW:0] thr_s;
  logic                            step_up;
  logic                            step_dn;
  logic [rcs_pkg::ChanW:0]         cand;
  logic                            below;
  logic                            over;
  logic [rcs_pkg::ChanW-1:0]       next_ch;

  // transition lookup and count update
  assign delta = rcs_pkg::DELTA_TABLE[{state.previous_lines, line_a, line_b}];
  assign sum   = {state.detent_count[rcs_pkg::CountW-1], state.detent_count}
               + {{(rcs_pkg::CountW-1){delta[1]}}, delta};

  // zero threshold acts as one
  assign thr     = (cfg.step_threshold == '0) ? rcs_pkg::ThrW'(1) : cfg.step_threshold;
  assign thr_s   = $signed({2'b00, thr});
  assign step_up = (sum >= thr_s);
  assign step_dn = !step_up && (sum <= -thr_s);

  // candidate channel, one wider to see the upper end
  always_comb begin
    cand = {1'b0, state.current_channel};
    if (step_up) begin
      cand = {1'b0, state.current_channel} + (rcs_pkg::ChanW+1)'(1);
    end else if (step_dn) begin
      cand = {1'b0, state.current_channel} - (rcs_pkg::ChanW+1)'(1);
    end
  end

  assign below = step_dn && (state.current_channel == '0);
  assign over  = !below && (cand > {1'b0, cfg.channel_max});

  // wrap or clamp at the ends
  always_comb begin
    if (over) begin
      next_ch = cfg.wrap_enable ? '0 : cfg.channel_max;
    end else if (below) begin
      next_ch = cfg.wrap_enable ? cfg.channel_max : '0;
    end else begin
      next_ch = cand[rcs_pkg::ChanW-1:0];
    end
  end

  assign state_next.previous_lines  = {line_a, line_b};
  assign state_next.detent_count    = (step_up || step_dn) ? '0
                                    : sum[rcs_pkg::CountW-1:0];
  assign state_next.current_channel = next_ch;
  assign selected_channel           = next_ch;
  assign channel_changed            = (next_ch != state.current_channel);

endmodule

// ----- rtl/core/rcs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the rotary channel selector, bound to the top level.
// ----------------------------------------------------------------------------
module rcs_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [rcs_pkg::InDataW-1:0]       s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [rcs_pkg::OutDataW-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [rcs_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [rcs_pkg::CfgDataW-1:0]      cfg_wdata
);

  logic [rcs_pkg::ChanW-1:0] last_channel;
  logic                      out_xfer;

  assign out_xfer = m_tvalid && m_tready;

  // channel of the last delivered result, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_channel <= '0;
    end else if (out_xfer) begin
      last_channel <= m_tdata[rcs_pkg::ChanW-1:0];
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // changed flag agrees with the channel sequence
  assert property (@(posedge clk) disable iff (rst)
    out_xfer && !m_tdata[rcs_pkg::ChanW] |-> m_tdata[rcs_pkg::ChanW-1:0] == last_channel)
    else $error("channel moved without changed flag");

  assert property (@(posedge clk) disable iff (rst)
    out_xfer && m_tdata[rcs_pkg::ChanW] |-> m_tdata[rcs_pkg::ChanW-1:0] != last_channel)
    else $error("changed flag without channel move");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rotary_channel_selector rcs_checker u_rcs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotary channel selector. Encoder line pairs are
// streamed in as clean rotations, reversals and line noise under several
// register settings. A local decoder predicts every result, and the checker
// compares each output transfer against it.
// ----------------------------------------------------------------------------
module tb;

  // index past the last register, writes there must have no effect
  localparam logic [rcs_pkg::CfgIndexW-1:0] REG_UNUSED = 2'd3;

  localparam int IdleLimit     = 2000;
  localparam int DrainLimit    = 500;
  localparam int RandomPhases  = 10;
  localparam int ItemsPerPhase = 64;
  localparam int DirUp         = 1;
  localparam int DirDown       = -1;

  // quadrature delta, indexed by {previous a, previous b, a, b}
  localparam int QuadDelta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_HEAVY, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [rcs_pkg::ChanW-1:0] channel;
    logic                      changed;
  } chan_result_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [rcs_pkg::InDataW-1:0]   s_tdata;   // line_a, line_b
  logic                          m_tvalid;
  logic                          m_tready;
  logic [rcs_pkg::OutDataW-1:0]  m_tdata;   // selected_channel[3:0], channel_changed
  logic                          cfg_we;
  logic [rcs_pkg::CfgIndexW-1:0] cfg_index;
  logic [rcs_pkg::CfgDataW-1:0]  cfg_wdata;

  // decoder state and register copies of the predictor
  logic [rcs_pkg::LinesW-1:0] last_lines;
  int                         detent;
  logic [rcs_pkg::ChanW-1:0]  chan_now;
  logic [rcs_pkg::ThrW-1:0]   thr_reg;
  logic [rcs_pkg::ChanW-1:0]  max_reg;
  logic                       wrap_reg;

  chan_result_t expected_results [$];
  chan_result_t got_res;
  chan_result_t want_res;

  int       errors;
  int       samples_sent;
  int       results_seen;
  int       changes_seen;
  int       config_phases;
  int       input_stalls;
  int       idle_cycles;
  int       burst_left;
  bit       gaps_on;
  rx_mode_t rx_mode;
  int       rx_tick;
  int       hold_len;
  int       hold_seq;
  int       hold_seen;
  int       hold_left;

  rotary_channel_selector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predict the channel for one line pair, {a, b}, and advance the state
  function automatic chan_result_t decode_lines(logic [rcs_pkg::LinesW-1:0] lines);
    int           count;
    int           cand;
    int           thr;
    chan_result_t r;
    thr = (thr_reg == 0) ? 1 : int'(thr_reg);
    count = detent + QuadDelta[{last_lines, lines}];
    cand = int'(chan_now);
    last_lines = lines;
    if (count >= thr) begin
      cand++;
      count = 0;
    end else if (count <= -thr) begin
      cand--;
      count = 0;
    end
    detent = count;
    if (cand > int'(max_reg)) begin
      r.channel = wrap_reg ? '0 : max_reg;
    end else if (cand < 0) begin
      r.channel = wrap_reg ? max_reg : '0;
    end else begin
      r.channel = cand[rcs_pkg::ChanW-1:0];
    end
    r.changed = (r.channel != chan_now);
    chan_now = r.channel;
    return r;
  endfunction

  // next gray code pair in the given direction, up runs 00 10 11 01
  function automatic logic [rcs_pkg::LinesW-1:0] step_lines(int dir);
    logic [rcs_pkg::LinesW-1:0] nxt;
    case (last_lines)
      2'b00:   nxt = (dir > 0) ? 2'b10 : 2'b01;
      2'b10:   nxt = (dir > 0) ? 2'b11 : 2'b00;
      2'b11:   nxt = (dir > 0) ? 2'b01 : 2'b10;
      default: nxt = (dir > 0) ? 2'b00 : 2'b11;
    endcase
    return nxt;
  endfunction

  // offer one line pair {a, b}, with a random gap between bursts
  task automatic send_lines(logic [rcs_pkg::LinesW-1:0] lines);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(rcs_pkg::InDataW-2){1'b0}}, lines[0], lines[1]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(decode_lines(lines));
    samples_sent++;
  endtask

  task automatic turn(int dir, int count);
    repeat (count) send_lines(step_lines(dir));
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [rcs_pkg::CfgIndexW-1:0] idx,
                           logic [rcs_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      rcs_pkg::REG_STEP_THRESHOLD: thr_reg = val;
      rcs_pkg::REG_CHANNEL_MAX:    max_reg = val;
      rcs_pkg::REG_WRAP_ENABLE:    wrap_reg = val[0];
      default: ;
    endcase
  endtask

  // write all registers plus the unused index, only while idle
  task automatic configure(int thr, int maxc, bit wrap);
    drain();
    write_reg(rcs_pkg::REG_STEP_THRESHOLD, 4'(thr));
    write_reg(rcs_pkg::REG_CHANNEL_MAX, 4'(maxc));
    write_reg(rcs_pkg::REG_WRAP_ENABLE, {3'($urandom), wrap});
    write_reg(REG_UNUSED, 4'($urandom));
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // reset values, one full detent, illegal double jumps and repeats
  task automatic test_defaults();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    turn(DirUp, 6);
    send_lines(~last_lines);
    send_lines(~last_lines);
    send_lines(last_lines);
  endtask

  // zero threshold acts as one, stepping below zero wraps to the max
  task automatic test_zero_threshold_wrap();
    configure(0, 15, 1'b1);
    turn(DirDown, 3);
  endtask

  // channel above max clamps down, clamp at both ends
  task automatic test_clamp_ends();
    configure(1, 2, 1'b0);
    rx_mode = RX_PATTERN;
    turn(DirUp, 2);
    turn(DirDown, 4);
  endtask

  // channel above max wraps to zero even without a step
  task automatic test_wrap_above_max();
    configure(1, 15, 1'b1);
    turn(DirUp, 3);
    configure(1, 1, 1'b1);
    send_lines(last_lines);
    configure(1, 0, 1'b1);
    turn(DirUp, 1);
  endtask

  // rotations with random content, reversals and noise over many settings
  task automatic test_random_turns();
    int n;
    int kind;
    int len;
    int thr;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: configure(15, 15, 1'b1);
        1: configure(1, 0, 1'b0);
        2: configure(0, 15, 1'b0);
        3: configure(15, 0, 1'b0);
        default: begin
          thr = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(5, 15);
          configure(thr, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end
      endcase
      rx_mode = rx_mode_t'(p % 4);
      gaps_on = (p % 3) != 1;
      n = 0;
      while (n < ItemsPerPhase) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          len = $urandom_range(1, 2 * int'(thr_reg) + 2);
          turn($urandom_range(0, 1) ? DirUp : DirDown, len);
        end else if (kind < 9) begin
          len = $urandom_range(1, 4);
          repeat (len) send_lines(2'($urandom));
        end else begin
          len = $urandom_range(2, 6);
          for (int k = 0; k < len; k++) send_lines(step_lines((k % 2) ? DirUp : DirDown));
        end
        n += len;
      end
    end
  endtask

  // long receiver hold while samples keep coming, the input must stall
  task automatic test_backpressure();
    configure(2, 7, 1'b1);
    rx_mode  = RX_ALWAYS;
    gaps_on  = 1'b0;
    hold_len = 60;
    hold_seq++;
    turn(DirUp, 40);
  endtask

  // result checker and receiver stall generator
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.channel = m_tdata[rcs_pkg::ChanW-1:0];
      got_res.changed = m_tdata[rcs_pkg::ChanW];
      results_seen++;
      if (got_res.changed) changes_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result channel=%0d changed=%0b", $time,
                 got_res.channel, got_res.changed);
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.channel != want_res.channel) begin
          errors++;
          $display("%0t: selected_channel expected %0d actual %0d", $time,
                   want_res.channel, got_res.channel);
        end
        if (got_res.changed != want_res.changed) begin
          errors++;
          $display("%0t: channel_changed expected %0b actual %0b", $time,
                   want_res.changed, got_res.changed);
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:   m_tready <= 1'($urandom_range(0, 1));
        default:    m_tready <= (rx_tick % 7) < 4;
      endcase
    end
  end

  // watchdog on cycles without any transfer, and count of input stall cycles
  always @(posedge clk) begin
    if (s_tvalid && !s_tready && !rst) input_stalls++;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    last_lines = '0;
    detent    = 0;
    chan_now  = '0;
    thr_reg   = rcs_pkg::STEP_THRESHOLD_RST;
    max_reg   = rcs_pkg::CHANNEL_MAX_RST;
    wrap_reg  = rcs_pkg::WRAP_ENABLE_RST;
    errors = 0; samples_sent = 0; results_seen = 0; changes_seen = 0;
    config_phases = 0; input_stalls = 0; idle_cycles = 0; burst_left = 0;
    gaps_on = 1'b0; rx_mode = RX_ALWAYS; rx_tick = 0;
    hold_len = 0; hold_seq = 0; hold_seen = 0; hold_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_zero_threshold_wrap();
    test_clamp_ends();
    test_wrap_above_max();
    test_random_turns();
    test_backpressure();

    drain();
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("run covered %0d encoder samples and %0d results, %0d channel changes",
             samples_sent, results_seen, changes_seen);
    $display("%0d register settings, %0d input stall cycles under output hold",
             config_phases, input_stalls);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
